### hdl/layer_normalization_unit_macros.svh
// assertion helpers for the layer normalization unit
`ifndef LAYER_NORMALIZATION_UNIT_MACROS_SVH
`define LAYER_NORMALIZATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LNU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LNU_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LNU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define LNU_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### hdl/lnu_pkg.sv
`default_nettype none
package lnu_pkg;
    localparam int MAX_ROW = 64;
    localparam int AW = $clog2(MAX_ROW);
    localparam int CW = AW + 1;

    typedef struct packed {
        logic signed [15:0] sample;
        logic signed [15:0] gain;
        logic signed [15:0] offset;
        logic               row_end;
    } t_in;

    typedef struct packed {
        logic signed [15:0] normalized;
        logic [5:0]         position;
        logic               clipped;
        logic               last_out;
    } t_out;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_MEAN  = 8'b0000_0010,
        S_VAR   = 8'b0000_0100,
        S_VDIV  = 8'b0000_1000,
        S_SQRT  = 8'b0001_0000,
        S_INV   = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic          load;
        logic          clear;
        logic          div_start;
        logic [1:0]    div_sel;
        logic          acc_sq;
        logic          sqrt_start;
        logic          emit;
        logic [AW-1:0] addr;
        logic          last;
    } t_cmd;

    typedef struct packed {
        logic          div_done;
        logic          sqrt_done;
        logic [CW-1:0] count;
        logic          full;
    } t_sts;

    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_VAR  = 2'd1;
    localparam logic [1:0] DIV_INV  = 2'd2;
endpackage
`default_nettype wire

### hdl/layer_normalization_unit.sv
// layer normalization unit: one input transaction per cycle while loading a row
// on the row end: mean divide, variance over the elements, variance divide, square root,
// inverse divide, emit of each element through the output pipeline, then drain
// busy is high from the row end until the drain ends; results cannot be stalled
// synchronous active-low reset clears control, count, sum, truncation and epsilon (to 1)
`default_nettype none
`include "layer_normalization_unit_macros.svh"
module layer_normalization_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire lnu_pkg::t_in i_item,
    input  wire logic         i_eps_we,
    input  wire logic [15:0]  i_eps_data,
    output lnu_pkg::t_out     o_result,
    output logic              o_result_stb
);
    logic [15:0] r_eps;
    lnu_pkg::t_cmd w_cmd;
    lnu_pkg::t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 16'd1;
        end else if (i_eps_we) begin
            r_eps <= i_eps_data;
        end
    end

    lnu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_row_end (i_item.row_end),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .busy      (busy)
    );

    lnu_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_item),
        .i_eps    (r_eps),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_result),
        .o_valid  (o_result_stb)
    );

    `LNU_ASSERT_NEVER(a_no_out_idle, i_clk, i_rst_n, o_result_stb && !busy && !$past(busy), "result while idle")
    `LNU_ASSERT_IMPL(a_load_only_idle, i_clk, i_rst_n, w_cmd.load |-> !busy, "load while busy")
    `LNU_ASSERT_NEVER(a_one_cmd, i_clk, i_rst_n, w_cmd.div_start && w_cmd.sqrt_start, "two units started")
endmodule
`default_nettype wire

### hdl/lnu_ctrl.sv
`default_nettype none
module lnu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_row_end,
    input  wire lnu_pkg::t_sts i_sts,
    output lnu_pkg::t_cmd      o_cmd,
    output logic               busy
);
    lnu_pkg::t_state r_state, n_state;
    logic [lnu_pkg::AW-1:0] r_addr, n_addr;
    logic [1:0] r_ph, n_ph;
    logic [lnu_pkg::CW-1:0] w_lastidx;

    assign w_lastidx = i_sts.count - lnu_pkg::CW'(1);
    assign busy = (r_state != lnu_pkg::S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lnu_pkg::S_LOAD;
            r_addr  <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_ph    <= n_ph;
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_ph    = r_ph;
        o_cmd   = '0;
        o_cmd.addr = r_addr;
        case (r_state)
            lnu_pkg::S_LOAD: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_row_end) begin
                        n_state = lnu_pkg::S_MEAN;
                        n_ph = '0;
                    end
                end
            end
            lnu_pkg::S_MEAN: begin
                if (r_ph == 2'd0) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = lnu_pkg::DIV_MEAN;
                    n_ph = 2'd1;
                end else if (i_sts.div_done) begin
                    n_state = lnu_pkg::S_VAR;
                    n_addr = '0;
                    n_ph = '0;
                end
            end
            lnu_pkg::S_VAR: begin
                // read issued at ph 0, difference formed at ph 1, squared and accumulated at ph 2
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else if (r_ph == 2'd1) begin
                    n_ph = 2'd2;
                end else begin
                    o_cmd.acc_sq = 1'b1;
                    n_ph = '0;
                    if ({1'b0, r_addr} == w_lastidx) begin
                        n_state = lnu_pkg::S_VDIV;
                        n_addr = '0;
                    end else begin
                        n_addr = r_addr + lnu_pkg::AW'(1);
                    end
                end
            end
            lnu_pkg::S_VDIV: begin
                if (r_ph == 2'd0) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = lnu_pkg::DIV_VAR;
                    n_ph = 2'd1;
                end else if (i_sts.div_done) begin
                    n_state = lnu_pkg::S_SQRT;
                    n_ph = '0;
                end
            end
            lnu_pkg::S_SQRT: begin
                if (r_ph == 2'd0) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_ph = 2'd1;
                end else if (i_sts.sqrt_done) begin
                    n_state = lnu_pkg::S_INV;
                    n_ph = '0;
                end
            end
            lnu_pkg::S_INV: begin
                if (r_ph == 2'd0) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = lnu_pkg::DIV_INV;
                    n_ph = 2'd1;
                end else if (i_sts.div_done) begin
                    n_state = lnu_pkg::S_EMIT;
                    n_ph = '0;
                    n_addr = '0;
                end
            end
            lnu_pkg::S_EMIT: begin
                // issue each element into the output pipeline at phase 2
                if (r_ph == 2'd2) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = ({1'b0, r_addr} == w_lastidx);
                    n_ph = '0;
                    if (o_cmd.last) begin
                        n_state = lnu_pkg::S_DONE;
                    end else begin
                        n_addr = r_addr + lnu_pkg::AW'(1);
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            lnu_pkg::S_DONE: begin
                // drain output pipeline, then clear row state
                if (r_ph == 2'd3) begin
                    o_cmd.clear = 1'b1;
                    n_state = lnu_pkg::S_LOAD;
                    n_ph = '0;
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            default: begin
                n_state = lnu_pkg::S_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/lnu_datapath.sv
`default_nettype none
module lnu_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lnu_pkg::t_in  i_in,
    input  wire logic [15:0]   i_eps,
    input  wire lnu_pkg::t_cmd i_cmd,
    output lnu_pkg::t_sts      o_sts,
    output lnu_pkg::t_out      o_result,
    output logic               o_valid
);
    localparam int AW = lnu_pkg::AW;
    localparam int CW = lnu_pkg::CW;

    logic [15:0] r_mem_s [lnu_pkg::MAX_ROW];
    logic [15:0] r_mem_g [lnu_pkg::MAX_ROW];
    logic [15:0] r_mem_o [lnu_pkg::MAX_ROW];
    logic signed [15:0] r_rd_s, r_rd_g, r_rd_o;

    logic [CW-1:0] r_count;
    logic signed [22:0] r_sum;
    logic r_trunc;
    logic w_full;

    logic signed [16:0] r_mean;
    logic [31:0] r_var;
    logic [39:0] r_sumsq;
    logic [32:0] r_s;
    logic [32:0] r_inv;

    assign w_full = (r_count == CW'(lnu_pkg::MAX_ROW));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_mem_s[r_count[AW-1:0]] <= i_in.sample;
            r_mem_g[r_count[AW-1:0]] <= i_in.gain;
            r_mem_o[r_count[AW-1:0]] <= i_in.offset;
        end
        r_rd_s <= r_mem_s[i_cmd.addr];
        r_rd_g <= r_mem_g[i_cmd.addr];
        r_rd_o <= r_mem_o[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_trunc <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_trunc <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_full) begin
                r_trunc <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
                r_sum   <= r_sum + 23'(i_in.sample);
            end
        end
    end

    // shared restoring divider, unsigned 64 by 40 bits, one quotient bit a cycle
    logic [63:0] r_dq;
    logic [39:0] r_drem;
    logic [39:0] r_dden;
    logic [6:0]  r_dcnt;
    logic        r_dbusy, r_dneg;
    logic [1:0]  r_dsel;
    logic [40:0] w_dtry;
    logic [40:0] w_dsub;
    logic [22:0] w_absum;

    assign w_absum = r_sum[22] ? 23'(-r_sum) : 23'(r_sum);
    assign w_dtry = {r_drem, r_dq[63]};
    assign w_dsub = w_dtry - {1'b0, r_dden};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= 7'd64;
        end else if (r_dbusy) begin
            if (r_dcnt == 7'd1) begin
                r_dbusy <= 1'b0;
            end
            r_dcnt <= r_dcnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_drem <= '0;
            r_dsel <= i_cmd.div_sel;
            case (i_cmd.div_sel)
                lnu_pkg::DIV_MEAN: begin
                    r_dq   <= 64'(w_absum);
                    r_dden <= 40'(r_count);
                    r_dneg <= r_sum[22];
                end
                lnu_pkg::DIV_VAR: begin
                    r_dq   <= 64'(r_sumsq);
                    r_dden <= 40'(r_count);
                    r_dneg <= 1'b0;
                end
                default: begin
                    r_dq   <= 64'h1 << 40;
                    r_dden <= 40'(r_s);
                    r_dneg <= 1'b0;
                end
            endcase
        end else if (r_dbusy) begin
            if (!w_dsub[40]) begin
                r_drem <= w_dsub[39:0];
                r_dq   <= {r_dq[62:0], 1'b1};
            end else begin
                r_drem <= w_dtry[39:0];
                r_dq   <= {r_dq[62:0], 1'b0};
            end
        end
    end

    logic r_dbusy_d;
    logic [32:0] w_vsum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy_d <= 1'b0;
        end else begin
            r_dbusy_d <= r_dbusy;
        end
    end
    assign o_sts.div_done = r_dbusy_d && !r_dbusy;
    assign w_vsum = 33'(r_dq[31:0]) + 33'(i_eps);

    always_ff @(posedge i_clk) begin
        if (o_sts.div_done) begin
            case (r_dsel)
                lnu_pkg::DIV_MEAN:
                    r_mean <= r_dneg ? -17'(r_dq[15:0]) : 17'(r_dq[15:0]);
                lnu_pkg::DIV_VAR:
                    r_var <= (w_vsum == '0) ? 32'd1 : w_vsum[31:0];
                default:
                    r_inv <= r_dq[32:0];
            endcase
        end
    end

    // variance accumulation
    logic signed [17:0] r_diff_v;
    logic signed [35:0] w_sq;
    assign w_sq = r_diff_v * r_diff_v;
    always_ff @(posedge i_clk) begin
        r_diff_v <= 18'(r_rd_s) - 18'(r_mean);
        if (i_cmd.div_start && i_cmd.div_sel == lnu_pkg::DIV_MEAN) begin
            r_sumsq <= '0;
        end else if (i_cmd.acc_sq) begin
            r_sumsq <= r_sumsq + 40'($unsigned(w_sq));
        end
    end

    // bitwise integer square root of var * 2^16, 24 steps
    logic [47:0] r_qv;
    logic [47:0] r_qbit;
    logic [47:0] r_qr;
    logic        r_qbusy, r_qbusy_d;
    logic [48:0] w_qrb;
    assign w_qrb = 49'(r_qr) + 49'(r_qbit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbusy <= 1'b0;
            r_qbusy_d <= 1'b0;
        end else begin
            r_qbusy_d <= r_qbusy;
            if (i_cmd.sqrt_start) begin
                r_qbusy <= 1'b1;
            end else if (r_qbusy && r_qbit == 48'd1) begin
                r_qbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_qv <= {r_var, 16'h0};
            r_qr <= '0;
            r_qbit <= 48'h1 << 46;
        end else if (r_qbusy) begin
            if (49'(r_qv) >= w_qrb) begin
                r_qv <= r_qv - w_qrb[47:0];
                r_qr <= (r_qr >> 1) + r_qbit;
            end else begin
                r_qr <= r_qr >> 1;
            end
            r_qbit <= r_qbit >> 2;
        end
    end
    assign o_sts.sqrt_done = r_qbusy_d && !r_qbusy;
    always_ff @(posedge i_clk) begin
        if (o_sts.sqrt_done) begin
            r_s <= r_qr[32:0];
        end
    end

    // emit pipeline: read, diff, d*inv, n*gain plus offset, round and saturate
    logic [3:0] r_ev;
    logic [3:0] r_el;
    logic [AW-1:0] r_ea0, r_ea1, r_ea2, r_ea3;
    logic signed [17:0] r_ediff;
    logic signed [15:0] r_eg1, r_eo1, r_eg2, r_eo2;
    logic signed [51:0] r_prod;
    logic signed [51:0] w_n;
    logic signed [67:0] r_t;
    logic signed [51:0] w_r;
    logic w_sat_hi, w_sat_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
        end else begin
            r_ev <= {r_ev[2:0], i_cmd.emit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_el   <= {r_el[2:0], i_cmd.last};
        r_ea0  <= i_cmd.addr;
        r_ea1  <= r_ea0;
        r_ea2  <= r_ea1;
        r_ea3  <= r_ea2;
        r_ediff <= 18'(r_rd_s) - 18'(r_mean);
        r_eg1  <= r_rd_g;
        r_eo1  <= r_rd_o;
        r_prod <= 52'(r_ediff) * 52'($signed({1'b0, r_inv}));
        r_eg2  <= r_eg1;
        r_eo2  <= r_eo1;
        r_t    <= 68'(w_n) * 68'(r_eg2) + (68'(r_eo2) <<< 16) + 68'sd32768;
    end

    assign w_n = r_prod >>> 16;
    assign w_r = 52'(r_t >>> 16);
    assign w_sat_hi = (w_r > 52'sd32767);
    assign w_sat_lo = (w_r < -52'sd32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_ev[3];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.normalized <= w_sat_hi ? 16'sh7fff : (w_sat_lo ? -16'sh8000 : w_r[15:0]);
        o_result.position   <= 6'(r_ea3);
        o_result.clipped    <= w_sat_hi || w_sat_lo || r_trunc;
        o_result.last_out   <= r_el[3];
    end

    assign o_sts.count = r_count;
    assign o_sts.full  = w_full;
endmodule
`default_nettype wire

### test/layer_normalization_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module layer_normalization_unit_tb;
    localparam int GAP_DRAIN  = -1;
    localparam int GAP_EPS    = -2;
    localparam int MODE_RAND  = 0;
    localparam int MODE_SMALL = 1;
    localparam int MODE_FLAT  = 2;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    lnu_pkg::t_in  item = '0;
    logic  eps_we = 1'b0;
    logic  [15:0] eps_data = 16'd0;
    lnu_pkg::t_out result;
    logic  result_stb;

    always #1 clk = ~clk;

    layer_normalization_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item),
        .i_eps_we    (eps_we),
        .i_eps_data  (eps_data),
        .o_result    (result),
        .o_result_stb(result_stb)
    );

    // pending transactions; negative gaps mark a drain wait or an epsilon write
    lnu_pkg::t_in  pending_items[$];
    int            pending_gaps[$];
    logic [15:0]   pending_eps[$];
    lnu_pkg::t_out expected_results[$];

    // row state kept by the predictor
    logic signed [15:0] row_x[64];
    logic signed [15:0] row_g[64];
    logic signed [15:0] row_o[64];
    int           row_len = 0;
    longint       row_sum = 0;
    bit           row_trunc = 0;
    longint       eps_value = 1;

    int  mismatches = 0;
    int  queued = 0;
    bit  stim_done = 0;

    function automatic longint floor_div_pow2(longint a, int k);
        if (a >= 0) return a >>> k;
        return -(((-a) + ((longint'(1) << k) - 1)) >>> k);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, bit_val;
        r = 0;
        bit_val = longint'(1) << 62;
        while (bit_val > v) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (v >= r + bit_val) begin
                v = v - (r + bit_val);
                r = (r >> 1) + bit_val;
            end else begin
                r = r >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return r;
    endfunction

    task automatic predict_norm(input lnu_pkg::t_in it);
        longint mean, d, sumsq, v, s, inv, n, t, r;
        bit     sat;
        lnu_pkg::t_out o;
        if (row_len < lnu_pkg::MAX_ROW) begin
            row_x[row_len] = it.sample;
            row_g[row_len] = it.gain;
            row_o[row_len] = it.offset;
            row_sum += it.sample;
            row_len++;
        end else begin
            row_trunc = 1;
        end
        if (!it.row_end) return;
        mean = row_sum / row_len;
        sumsq = 0;
        for (int i = 0; i < row_len; i++) begin
            d = longint'(row_x[i]) - mean;
            sumsq += d * d;
        end
        v = sumsq / row_len + eps_value;
        if (v == 0) v = 1;
        s = int_sqrt(v << 16);
        inv = (longint'(1) << 40) / s;
        for (int i = 0; i < row_len; i++) begin
            d = longint'(row_x[i]) - mean;
            n = floor_div_pow2(d * inv, 16);
            t = n * longint'(row_g[i]) + longint'(row_o[i]) * 65536;
            r = floor_div_pow2(t + 32768, 16);
            sat = 0;
            if (r > 32767) begin
                r = 32767;
                sat = 1;
            end
            if (r < -32768) begin
                r = -32768;
                sat = 1;
            end
            o.normalized = r[15:0];
            o.position = i[5:0];
            o.clipped = sat | row_trunc;
            o.last_out = (i + 1 == row_len);
            expected_results = {expected_results, o};
        end
        row_len = 0;
        row_sum = 0;
        row_trunc = 0;
    endtask

    task automatic add_item(input logic [15:0] x, input logic [15:0] g,
                            input logic [15:0] o, input bit last, input int gap);
        lnu_pkg::t_in it;
        it.sample = x;
        it.gain = g;
        it.offset = o;
        it.row_end = last;
        pending_items = {pending_items, it};
        pending_gaps = {pending_gaps, gap};
        queued++;
    endtask

    task automatic add_eps(input logic [15:0] e);
        lnu_pkg::t_in it;
        it = '0;
        pending_items = {pending_items, it};
        pending_gaps = {pending_gaps, GAP_EPS};
        pending_eps = {pending_eps, e};
    endtask

    task automatic add_drain();
        lnu_pkg::t_in it;
        it = '0;
        pending_items = {pending_items, it};
        pending_gaps = {pending_gaps, GAP_DRAIN};
    endtask

    task automatic add_row(input int len, input int mode);
        logic [15:0] x;
        int gap;
        for (int i = 0; i < len; i++) begin
            case (mode)
                MODE_RAND: x = 16'($urandom);
                MODE_SMALL: x = 16'($urandom_range(0, 255) - 128);
                default: x = 16'h0100;
            endcase
            gap = int'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
            add_item(x, 16'($urandom), 16'($urandom), i == len - 1, gap);
        end
    endtask

    // driver
    int          wait_cnt = 0;
    bit          driving = 0;
    int          drain_cnt = 0;
    bit          busy_q = 1'b1;
    always @(negedge clk) begin
        bit eps_we_n;
        eps_we_n = 1'b0;
        if (rst_n) begin
            if (driving && !busy_q) begin
                driving = 0;
            end
            if (!driving) begin
                if (wait_cnt > 0) begin
                    wait_cnt--;
                    start <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    if (pending_gaps[0] < 0) begin
                        start <= 1'b0;
                        if (expected_results.size() == 0 && drain_cnt >= 20) begin
                            if (pending_gaps[0] == GAP_EPS) begin
                                eps_we_n = 1'b1;
                                eps_data <= pending_eps[0];
                                eps_value = pending_eps.pop_front();
                            end
                            void'(pending_items.pop_front());
                            void'(pending_gaps.pop_front());
                            drain_cnt = 0;
                        end else if (expected_results.size() == 0) begin
                            drain_cnt++;
                        end
                    end else begin
                        item <= pending_items[0];
                        start <= 1'b1;
                        driving = 1;
                        wait_cnt = pending_gaps[0];
                    end
                end else begin
                    start <= 1'b0;
                    stim_done = 1;
                end
            end
        end
        eps_we <= eps_we_n;
    end

    // acceptance and results at the rising edge
    always @(posedge clk) begin
        lnu_pkg::t_out exp_r;
        if (rst_n) begin
            if (start && !busy && driving) begin
                predict_norm(pending_items.pop_front());
                void'(pending_gaps.pop_front());
                busy_q <= 1'b0;
            end else begin
                busy_q <= 1'b1;
            end
            if (result_stb) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", result);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (result.normalized !== exp_r.normalized ||
                        result.position !== exp_r.position ||
                        result.clipped !== exp_r.clipped ||
                        result.last_out !== exp_r.last_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, result);
                    end
                end
            end
        end
    end

    initial begin
        int len;
        // directed rows
        add_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 0);
        add_item(16'h8000, 16'h8000, 16'h8000, 1'b0, 0);
        add_item(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 0);
        add_item(16'h0100, 16'h0100, 16'h0000, 1'b0, 0);
        add_item(16'h0100, 16'h0100, 16'h0000, 1'b0, 0);
        add_item(16'h0100, 16'hFF00, 16'hFFFF, 1'b1, 0);
        add_item(16'hFF80, 16'h0100, 16'h0000, 1'b0, 1);
        add_item(16'h0080, 16'h0100, 16'h0000, 1'b1, 2);
        add_item(16'h1234, 16'h5555, 16'hAAAA, 1'b0, 0);
        add_item(16'hEDCB, 16'hAAAA, 16'h5555, 1'b1, 0);
        add_drain();
        add_eps(16'd0);
        add_row(2, MODE_FLAT);
        add_row(3, MODE_SMALL);
        add_eps(16'hFFFF);
        add_row(4, MODE_RAND);
        add_row(3, MODE_SMALL);
        add_eps(16'd0);
        // row beyond the store, with dropped items and row end on a dropped one
        add_row(67, MODE_SMALL);
        add_eps(16'd1);
        // random rows, mostly short
        while (queued < 110) begin
            len = int'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                   : $urandom_range(1, 6));
            add_row(len, ($urandom_range(0, 2) == 0) ? MODE_SMALL : MODE_RAND);
            if ($urandom_range(0, 7) == 0) add_eps(16'($urandom));
        end
        add_eps(16'h8000);
        add_row(5, MODE_RAND);
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("layer_normalization_unit regression: pass");
        else
            $display("layer_normalization_unit regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("layer_normalization_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
